@@ rtl/bdq_pkg.sv @@
// bdq_pkg: shared types for the bounded deque with search
// command, status, chain operation and sequencer state codes
// no dependencies
package bdq_pkg;

	// command codes carried in s_tuser
	typedef enum logic [2:0] {
		CMD_TRAVERSE     = 3'd0,
		CMD_INSERT_FRONT = 3'd1,
		CMD_INSERT_BACK  = 3'd2,
		CMD_DELETE_FRONT = 3'd3,
		CMD_DELETE_BACK  = 3'd4,
		CMD_SEARCH       = 3'd5
	} cmd_t;

	// status codes carried in m_tuser
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// operation applied to all cells of the chain together
	typedef enum logic [2:0] {
		OP_HOLD = 3'd0,   // keep contents
		OP_SHR  = 3'd1,   // shift toward the back, new word enters cell 0
		OP_SHL  = 3'd2,   // shift toward the front, cell 0 drops out
		OP_ROTL = 3'd3,   // rotate the occupied cells by one toward the front
		OP_LOAD = 3'd4    // write the new word into the first free cell
	} chain_op_t;

	// control bundle from the sequencer to the cells
	typedef struct packed {
		chain_op_t op;
	} chain_ctl_t;

	// sequencer states
	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} state_t;

endpackage

@@ rtl/bdq_cell.sv @@
// bdq_cell: one storage cell of the deque chain
// holds the entry at position INDEX from the front; uses bdq_pkg
module bdq_cell
	import bdq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	parameter int INDEX      = 0,
	localparam int CW        = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  chain_ctl_t            ctl,
	input  logic [CW-1:0]         count,
	input  logic [VALUE_BITS-1:0] left_val,
	input  logic [VALUE_BITS-1:0] right_val,
	input  logic [VALUE_BITS-1:0] front_val,
	input  logic [VALUE_BITS-1:0] ins_val,
	output logic [VALUE_BITS-1:0] val_q
);

	localparam logic [CW-1:0] POS_NEXT = CW'(INDEX + 1);
	localparam logic [CW-1:0] POS_SELF = CW'(INDEX);

	logic is_tail;
	logic is_inner;
	logic is_free_slot;

	// position of this cell relative to the occupied run
	assign is_tail      = (count == POS_NEXT);
	assign is_inner     = (count > POS_NEXT);
	assign is_free_slot = (count == POS_SELF);

	// payload register, no reset
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_SHR: val_q <= left_val;
			OP_SHL: val_q <= right_val;
			OP_ROTL: begin
				if (is_inner) begin
					val_q <= right_val;
				end else if (is_tail) begin
					val_q <= front_val;
				end
			end
			OP_LOAD: begin
				if (is_free_slot) begin
					val_q <= ins_val;
				end
			end
			default: val_q <= val_q;
		endcase
	end

endmodule

@@ rtl/bdq_ctrl.sv @@
// bdq_ctrl: command sequencer, entry count and result word register
// drives the cell chain operation; uses bdq_pkg
module bdq_ctrl
	import bdq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	localparam int CW        = $clog2(CAPACITY + 1),
	localparam int SW        = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            in_cmd,
	input  logic [VALUE_BITS-1:0] in_value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            out_status,
	output logic [VALUE_BITS-1:0] out_data,
	output logic                  out_last,
	input  logic [VALUE_BITS-1:0] front_val,
	output chain_ctl_t            ctl,
	output logic [CW-1:0]         count
);

	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE        = CW'(1);

	state_t                  state_q, state_d;
	cmd_t                    cmd_q;
	cmd_t                    cmd_in;
	logic [VALUE_BITS-1:0]   key_q;
	logic [SW-1:0]           step_q;
	logic                    found_q;
	logic [CW-1:0]           count_q, count_d;
	logic                    out_valid_q;
	status_t                 status_q, status_d;
	logic [VALUE_BITS-1:0]   data_q, data_d;
	logic                    last_q, last_d;
	logic                    emit;
	logic                    out_free;
	logic                    in_acc;
	logic                    advance;
	logic                    is_empty;
	logic                    is_full;
	logic                    is_final;
	logic                    match;

	assign cmd_in   = cmd_t'(in_cmd);
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;
	assign advance  = (state_q == S_WALK) && out_free;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == FULL_COUNT);
	assign is_final = ((CW'(step_q) + ONE) == count_q);
	assign match    = (front_val == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && !is_empty && (cmd_in == CMD_TRAVERSE ||
						cmd_in == CMD_SEARCH || cmd_in == CMD_DELETE_BACK)) begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (advance && is_final) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// chain operation, count update and result word
	always_comb begin
		ctl.op   = OP_HOLD;
		count_d  = count_q;
		emit     = 1'b0;
		status_d = ST_OK;
		data_d   = '0;
		last_d   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (cmd_in)
						CMD_TRAVERSE, CMD_SEARCH, CMD_DELETE_BACK: begin
							if (is_empty) begin
								emit     = 1'b1;
								status_d = ST_EMPTY;
							end
						end
						CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
							emit = 1'b1;
							if (is_full) begin
								status_d = ST_FULL;
							end else begin
								ctl.op  = (cmd_in == CMD_INSERT_FRONT) ? OP_SHR : OP_LOAD;
								count_d = count_q + ONE;
							end
						end
						CMD_DELETE_FRONT: begin
							emit = 1'b1;
							if (is_empty) begin
								status_d = ST_EMPTY;
							end else begin
								data_d  = front_val;
								ctl.op  = OP_SHL;
								count_d = count_q - ONE;
							end
						end
						default: ;
					endcase
				end
			end
			S_WALK: begin
				if (advance) begin
					case (cmd_q)
						CMD_TRAVERSE: begin
							ctl.op = OP_ROTL;
							emit   = 1'b1;
							data_d = front_val;
							last_d = is_final;
						end
						CMD_SEARCH: begin
							ctl.op   = OP_ROTL;
							emit     = is_final;
							status_d = (found_q || match) ? ST_FOUND : ST_NOT_FOUND;
						end
						default: begin
							// delete back: rotate the back word to the front, then drop it
							if (is_final) begin
								ctl.op  = OP_SHL;
								emit    = 1'b1;
								data_d  = front_val;
								count_d = count_q - ONE;
							end else begin
								ctl.op = OP_ROTL;
							end
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			found_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (advance) begin
				step_q  <= step_q + SW'(1);
				found_q <= found_q || match;
			end
		end
	end

	// command, key and result word payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd_in;
			key_q <= in_value;
		end
		if (emit) begin
			status_q <= status_d;
			data_q   <= data_d;
			last_q   <= last_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_data   = data_q;
	assign out_last   = last_q;
	assign count      = count_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above capacity");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (CW'(step_q) < count_q))
		else $error("walk step outside occupied cells");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_full && (cmd_in == CMD_INSERT_FRONT || cmd_in == CMD_INSERT_BACK))
		|=> (count_q == $past(count_q)) && out_valid_q)
		else $error("insert into full list changed the count");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("result word overwritten before it was taken");

endmodule

@@ rtl/bounded_deque_with_search.sv @@
// bounded_deque_with_search: top level, a chain of bdq_cell plus bdq_ctrl
// depends on bdq_pkg, bdq_cell, bdq_ctrl
//
// A double-ended queue of up to CAPACITY signed words, held front to back in a row of
// cells: cell 0 is always the front. The command on s_tuser inserts at the front or back,
// deletes from the front or back (returning the word), searches for a key or traverses
// the list; each command gives one result word, except traverse, which gives one word per
// entry with m_tlast on the final one (one word on an empty list), and the unused codes
// 6 and 7, which give none. Inserts and delete front complete in the cycle in which
// they are taken. Traverse, search and delete back on a non-empty list step the chain
// by one position per cycle after the cycle in which they are taken, holding the input
// until every entry has been passed; delete back rotates the back entry to cell 0 and
// then drops it. A new command is taken once the previous one has finished and the
// result register is free or being emptied. Stalls on m_tready hold the chain in place.
module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	localparam int DW        = ((VALUE_BITS + 7) / 8) * 8,
	localparam int CW        = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // value
	input  logic [7:0]    s_tuser,   // command
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata,   // data_out
	output logic [7:0]    m_tuser,   // status
	output logic          m_tlast
);

	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [VALUE_BITS-1:0] in_value;
	logic [VALUE_BITS-1:0] out_data;
	logic [2:0]            out_status;
	chain_ctl_t            ctl;
	logic [CW-1:0]         count;

	assign in_value = s_tdata[VALUE_BITS-1:0];

	// sequencer
	bdq_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser[2:0]),
		.in_value   (in_value),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_data   (out_data),
		.out_last   (m_tlast),
		.front_val  (cell_val[0]),
		.ctl        (ctl),
		.count      (count)
	);

	// chain of cells, each linked to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_val;
		logic [VALUE_BITS-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = in_value;
		end else begin : g_mid
			assign left_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_val = cell_val[i];
		end else begin : g_inner
			assign right_val = cell_val[i+1];
		end

		bdq_cell #(
			.CAPACITY   (CAPACITY),
			.VALUE_BITS (VALUE_BITS),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count),
			.left_val  (left_val),
			.right_val (right_val),
			.front_val (cell_val[0]),
			.ins_val   (in_value),
			.val_q     (cell_val[i])
		);
	end

	assign m_tdata = DW'(out_data);
	assign m_tuser = {5'd0, out_status};

endmodule

@@ tb/sv/bdq_checker.sv @@
// bdq_checker: watches both stream channels of the bounded deque, predicts every
// result word from the accepted commands and compares them in order
// depends on bdq_pkg
`timescale 1ns / 100ps

module bdq_checker
	import bdq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	localparam int DW        = ((VALUE_BITS + 7) / 8) * 8,
	localparam int CW        = $clog2(CAPACITY + 1),
	localparam int HW        = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // value
	input  logic [7:0]    s_tuser,   // command
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [DW-1:0] m_tdata,   // data_out
	input  logic [7:0]    m_tuser,   // status
	input  logic          m_tlast,
	output int            fail_count,
	output int            words_checked,
	output int            words_pending
);

	typedef struct packed {
		status_t               status;
		logic [VALUE_BITS-1:0] data;
		logic                  last;
	} result_t;

	// result words owed by the block, oldest first
	result_t owed_words[$];

	// shadow copy of the deque: ring store, front position, entries held
	logic [VALUE_BITS-1:0] ring [CAPACITY];
	logic [HW-1:0]         head;
	logic [CW-1:0]         held;

	int fails;
	int checked;

	function automatic int unsigned slot(input int unsigned offset);
		return (head + offset) % CAPACITY;
	endfunction

	task automatic owe(input status_t st, input logic [VALUE_BITS-1:0] data, input logic last);
		owed_words.push_back('{status: st, data: data, last: last});
	endtask

	// apply one command to the shadow deque and queue the words it must produce
	task automatic predict_command(input logic [2:0] code, input logic [VALUE_BITS-1:0] key);
		bit hit;
		hit = 1'b0;
		case (code)
			CMD_TRAVERSE: begin
				if (held == 0)
					owe(ST_EMPTY, '0, 1'b1);
				else
					for (int k = 0; k < held; k++)
						owe(ST_OK, ring[slot(k)], k == held - 1);
			end
			CMD_INSERT_FRONT: begin
				if (held == CAPACITY) begin
					owe(ST_FULL, '0, 1'b1);
				end else begin
					head = HW'((head + CAPACITY - 1) % CAPACITY);
					ring[head] = key;
					held++;
					owe(ST_OK, '0, 1'b1);
				end
			end
			CMD_INSERT_BACK: begin
				if (held == CAPACITY) begin
					owe(ST_FULL, '0, 1'b1);
				end else begin
					ring[slot(held)] = key;
					held++;
					owe(ST_OK, '0, 1'b1);
				end
			end
			CMD_DELETE_FRONT: begin
				if (held == 0) begin
					owe(ST_EMPTY, '0, 1'b1);
				end else begin
					owe(ST_OK, ring[head], 1'b1);
					head = HW'(slot(1));
					held--;
				end
			end
			CMD_DELETE_BACK: begin
				if (held == 0) begin
					owe(ST_EMPTY, '0, 1'b1);
				end else begin
					owe(ST_OK, ring[slot(held - 1)], 1'b1);
					held--;
				end
			end
			CMD_SEARCH: begin
				if (held == 0) begin
					owe(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int k = 0; k < held; k++)
						if (ring[slot(k)] == key)
							hit = 1'b1;
					owe(hit ? ST_FOUND : ST_NOT_FOUND, '0, 1'b1);
				end
			end
			// unused codes leave the deque alone and produce nothing
			default: ;
		endcase
	endtask

	task automatic note_failure(input string what, input result_t want, input result_t got);
		fails++;
		if (fails <= 10)
			$display("%t %s: expected status %0d data %h last %b, got status %0d data %h last %b",
				$time, what, want.status, want.data, want.last,
				got.status, got.data, got.last);
	endtask

	// commands first, so a word caused in the same cycle would find its expectation
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			owed_words.delete();
			head = '0;
			held = '0;
			fails = 0;
			checked = 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_command(s_tuser[2:0], s_tdata[VALUE_BITS-1:0]);
			if (m_tvalid && m_tready) begin
				got = '{status: status_t'(m_tuser[2:0]), data: m_tdata[VALUE_BITS-1:0],
					last: m_tlast};
				checked++;
				if (owed_words.size() == 0) begin
					note_failure("unexpected result word", '0, got);
				end else begin
					want = owed_words.pop_front();
					if (got.status !== want.status || got.data !== want.data ||
							got.last !== want.last)
						note_failure("result word mismatch", want, got);
				end
			end
		end
		fail_count <= fails;
		words_checked <= checked;
		words_pending <= owed_words.size();
	end

endmodule

@@ tb/sv/tb_bounded_deque_with_search.sv @@
// tb_bounded_deque_with_search: stimulus and verdict for the bounded deque
// depends on bdq_pkg, bounded_deque_with_search and bdq_checker
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;
	import bdq_pkg::*;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int DW         = 32;

	// command codes the block ignores
	localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	// bias of a random round
	typedef enum int {
		MIX_GROW,
		MIX_ANY,
		MIX_SHRINK
	} mix_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;   // value
	logic [7:0]    s_tuser = '0;   // command
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [DW-1:0] m_tdata;        // data_out
	logic [7:0]    m_tuser;        // status
	logic          m_tlast;

	int fail_count;
	int words_checked;
	int words_pending;

	// stimulus-side bookkeeping, used to steer the random rounds and for the summary
	bit              idle_on = 1'b0;
	int              held = 0;
	int              fills = 0;
	int              commands_sent = 0;
	logic [DW-1:0]   recent [8];
	int              recent_ptr = 0;
	int              stall_left = 0;

	bounded_deque_with_search #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	bdq_checker #(
		.CAPACITY(CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.words_checked(words_checked),
		.words_pending(words_pending)
	);

	always #1 clk = ~clk;

	// receiver stalls in random bursts while idling is on
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(9, 1) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// offer one command word and wait for it to be taken
	task automatic send_word(input logic [2:0] code, input logic [DW-1:0] val);
		int gap;
		if (idle_on && $urandom_range(3) == 0) begin
			gap = $urandom_range(9, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {5'd0, code};
		s_tdata <= val;
		do @(posedge clk); while (!s_tready);
		if (code <= CMD_SEARCH)
			commands_sent++;
		case (code)
			CMD_INSERT_FRONT, CMD_INSERT_BACK: begin
				recent[recent_ptr] = val;
				recent_ptr = (recent_ptr + 1) % 8;
				if (held < CAPACITY) begin
					held++;
					if (held == CAPACITY)
						fills++;
				end
			end
			CMD_DELETE_FRONT, CMD_DELETE_BACK: begin
				if (held > 0)
					held--;
			end
			default: ;
		endcase
	endtask

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// one random command, biased toward growing, shrinking or neither
	task automatic random_item(input mix_t mix);
		int r;
		int ins_pct;
		int del_pct;
		logic [DW-1:0] v;
		v = pick_value();
		ins_pct = (mix == MIX_GROW) ? 65 : (mix == MIX_SHRINK) ? 10 : 30;
		del_pct = (mix == MIX_GROW) ? 10 : (mix == MIX_SHRINK) ? 65 : 30;
		r = $urandom_range(99);
		if ($urandom_range(99) < 3)
			send_word($urandom_range(1) ? CMD_UNUSED_6 : CMD_UNUSED_7, v);
		else if (r < ins_pct)
			send_word($urandom_range(1) ? CMD_INSERT_FRONT : CMD_INSERT_BACK, v);
		else if (r < ins_pct + del_pct)
			send_word($urandom_range(1) ? CMD_DELETE_FRONT : CMD_DELETE_BACK, v);
		else if ($urandom_range(4) < 3)
			// keys taken from recent inserts often hit
			send_word(CMD_SEARCH, (held > 0 && $urandom_range(1)) ?
				recent[$urandom_range(7)] : v);
		else
			send_word(CMD_TRAVERSE, v);
	endtask

	initial begin
		int round;
		int n;
		int extra;
		mix_t mix;

		for (int k = 0; k < 8; k++)
			recent[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty reports, extremes, one-entry corner cases, unused codes
		send_word(CMD_TRAVERSE, 32'h0000_0000);
		send_word(CMD_DELETE_FRONT, 32'h0000_0000);
		send_word(CMD_DELETE_BACK, 32'h0000_0000);
		send_word(CMD_SEARCH, 32'h0000_0000);
		send_word(CMD_INSERT_BACK, 32'h7fff_ffff);
		send_word(CMD_DELETE_BACK, 32'h0000_0000);
		send_word(CMD_INSERT_BACK, 32'h8000_0000);
		send_word(CMD_INSERT_FRONT, 32'h7fff_ffff);
		send_word(CMD_INSERT_FRONT, 32'h0000_0000);
		send_word(CMD_INSERT_BACK, 32'hffff_ffff);
		send_word(CMD_SEARCH, 32'hffff_ffff);
		send_word(CMD_SEARCH, 32'h7fff_fffe);
		send_word(CMD_SEARCH, 32'h8000_0000);
		send_word(CMD_TRAVERSE, 32'h0000_0000);
		send_word(CMD_UNUSED_6, 32'h1234_5678);
		send_word(CMD_UNUSED_7, 32'hffff_ffff);
		send_word(CMD_DELETE_FRONT, 32'h0000_0000);
		send_word(CMD_DELETE_BACK, 32'h0000_0000);
		send_word(CMD_TRAVERSE, 32'h0000_0000);

		// random rounds: grow to full, mix, drain to empty, with idling switched off
		// every fourth round and for the tail of the run
		round = 0;
		while (commands_sent < 100) begin
			mix = (round % 3 == 0) ? MIX_GROW : (round % 3 == 1) ? MIX_ANY : MIX_SHRINK;
			n = 0;
			extra = 0;
			while (n < 40 && extra < 3 && commands_sent < 100) begin
				idle_on = (round % 4 != 3) && commands_sent < 80;
				random_item(mix);
				n++;
				if ((mix == MIX_GROW && held == CAPACITY) || (mix == MIX_SHRINK && held == 0) ||
						(mix == MIX_ANY && n >= 14))
					extra++;
			end
			round++;
		end
		idle_on = 1'b0;
		s_tvalid <= 1'b0;

		// drain, then give a walk of the whole list time to show stray words
		while (words_pending != 0)
			@(posedge clk);
		repeat (3 * CAPACITY) @(posedge clk);

		$display("%0d commands accepted over %0d rounds, list filled %0d times",
			commands_sent, round, fills);
		$display("%0d result words checked, %0d failures, %0d words still owed",
			words_checked, fail_count, words_pending);
		if (fail_count == 0 && words_pending == 0)
			$display("PASS bounded_deque_with_search");
		else
			$display("FAIL bounded_deque_with_search");
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#500000;
		$display("FAIL bounded_deque_with_search");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_search.sv
tb/sv/bdq_checker.sv
tb/sv/tb_bounded_deque_with_search.sv
